>>> design/assert_macros.svh
// assertion macros shared by the transparent run-length encoder rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// implication checked in the next cycle
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next cycle check failed");

`endif

>>> design/trle_pkg.sv
// shared constants and types of the transparent run-length encoder
// no dependencies
`default_nettype none

package trle_pkg;

    localparam int MAX_RUN_DEF        = 127;
    localparam int MAX_WIDTH_DEF      = 4096;
    localparam int BYTES_PER_WORD_DEF = 8;

    localparam int PIXEL_W    = 8;
    localparam int CFG_W      = 13;
    localparam int WORD_W     = 64;
    localparam int COUNT_W    = 4;
    localparam int LANE_W     = 3;
    localparam int RUN_LEN_W  = 7;
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = 2;

    localparam logic [PIXEL_W-1:0] RUN_MARK = 8'h80;

    // class of the run closed first in a burst
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_TRANS  = 2'd1;
    localparam logic [1:0] KIND_OPAQUE = 2'd2;

    typedef struct packed {
        logic [1:0]           c1_kind;
        logic [RUN_LEN_W-1:0] c1_len;
        logic                 c1_bank;
        logic                 c2_opaque;
        logic [RUN_LEN_W-1:0] c2_len;
        logic                 c2_bank;
        logic                 marker;
    } cmd_t;

    typedef struct packed {
        logic                 en;
        logic                 bank;
        logic [RUN_LEN_W-1:0] addr;
        logic [PIXEL_W-1:0]   data;
    } lit_wr_t;

endpackage

`default_nettype wire

>>> design/trle_cmd_fifo.sv
// short command queue between front and back of the encoder
// depends on trle_pkg
`default_nettype none

module trle_cmd_fifo (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  trle_pkg::cmd_t      din,
    output logic                full,
    input  wire logic           pop,
    output trle_pkg::cmd_t      dout,
    output logic                empty
);

    localparam int PW = trle_pkg::CMDQ_PTR_W;
    localparam int CW = trle_pkg::CMDQ_PTR_W + 1;

    trle_pkg::cmd_t entry_reg [trle_pkg::CMDQ_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    assign full  = (count_reg == CW'(trle_pkg::CMDQ_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> design/trle_front.sv
// front of the encoder: row width register, column tracking, run classification
// depends on trle_pkg; feeds trle_cmd_fifo and the literal store in trle_back
`default_nettype none

module trle_front #(
    parameter int MAX_RUN   = trle_pkg::MAX_RUN_DEF,
    parameter int MAX_WIDTH = trle_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [trle_pkg::CFG_W-1:0]  cfg_row_width,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [trle_pkg::PIXEL_W-1:0] s_pixel,
    input  wire logic                        q_full,
    output logic                             q_push,
    output trle_pkg::cmd_t                   q_cmd,
    output trle_pkg::lit_wr_t                lit_wr,
    input  wire logic [1:0]                  bank_release
);

    localparam int COL_W = $clog2(MAX_WIDTH + 4);
    localparam int CW    = trle_pkg::CFG_W;
    localparam int PADW  = trle_pkg::CFG_W + 1;
    localparam int RL    = trle_pkg::RUN_LEN_W;

    logic [COL_W-1:0] wlast_reg, plast_reg, column_reg;
    logic [RL-1:0]    run_len_reg;
    logic             run_trans_reg;
    logic             cur_bank_reg;
    logic [1:0]       busy_reg;

    logic [CW-1:0]    w_clamp;
    logic [PADW-1:0]  w_pad;
    logic [COL_W-1:0] wlast_next, plast_next;

    logic             accept, in_row, is_trans, close1, starts, trans_new, use_bank, row_end;
    logic [RL-1:0]    len_base, len_new;
    logic [1:0]       busy_set;

    // clamp the width and precompute last pixel and last padded column
    always_comb begin
        if (cfg_row_width == '0) begin
            w_clamp = CW'(1);
        end else if (cfg_row_width > CW'(MAX_WIDTH)) begin
            w_clamp = CW'(MAX_WIDTH);
        end else begin
            w_clamp = cfg_row_width;
        end
        w_pad      = ({1'b0, w_clamp} + PADW'(3)) & ~PADW'(3);
        wlast_next = COL_W'(w_clamp - CW'(1));
        plast_next = COL_W'(w_pad - PADW'(1));
    end

    assign cfg_ready = 1'b1;
    // next opaque run goes to the other bank, which must be drained
    assign s_ready   = !q_full && !busy_reg[~cur_bank_reg];
    assign accept    = s_valid && s_ready;

    always_comb begin
        in_row    = (column_reg <= wlast_reg);
        is_trans  = (s_pixel == '0);
        close1    = in_row && (run_len_reg != '0)
                    && ((is_trans != run_trans_reg) || (run_len_reg >= RL'(MAX_RUN)));
        len_base  = close1 ? '0 : run_len_reg;
        starts    = (len_base == '0);
        trans_new = starts ? is_trans : run_trans_reg;
        use_bank  = (starts && !is_trans) ? ~cur_bank_reg : cur_bank_reg;
        len_new   = len_base + RL'(1);
        row_end   = in_row && (column_reg == wlast_reg);

        q_push = accept && (close1 || row_end);
        if (close1) begin
            q_cmd.c1_kind = run_trans_reg ? trle_pkg::KIND_TRANS : trle_pkg::KIND_OPAQUE;
        end else begin
            q_cmd.c1_kind = trle_pkg::KIND_NONE;
        end
        q_cmd.c1_len    = run_len_reg;
        q_cmd.c1_bank   = cur_bank_reg;
        q_cmd.c2_opaque = row_end && !trans_new;
        q_cmd.c2_len    = len_new;
        q_cmd.c2_bank   = use_bank;
        q_cmd.marker    = row_end;

        lit_wr.en   = accept && in_row && !is_trans;
        lit_wr.bank = use_bank;
        lit_wr.addr = len_base;
        lit_wr.data = s_pixel;

        busy_set = '0;
        if (q_push && (q_cmd.c1_kind == trle_pkg::KIND_OPAQUE)) begin
            busy_set[cur_bank_reg] = 1'b1;
        end
        if (q_push && q_cmd.c2_opaque) begin
            busy_set[use_bank] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlast_reg     <= '0;
            plast_reg     <= COL_W'(3);
            column_reg    <= '0;
            run_len_reg   <= '0;
            run_trans_reg <= 1'b0;
            cur_bank_reg  <= 1'b0;
            busy_reg      <= '0;
        end else begin
            busy_reg <= (busy_reg & ~bank_release) | busy_set;
            if (cfg_valid) begin
                wlast_reg     <= wlast_next;
                plast_reg     <= plast_next;
                column_reg    <= '0;
                run_len_reg   <= '0;
                run_trans_reg <= 1'b0;
            end else if (accept) begin
                column_reg <= (column_reg == plast_reg) ? '0 : column_reg + COL_W'(1);
                if (in_row) begin
                    run_len_reg   <= row_end ? '0 : len_new;
                    run_trans_reg <= trans_new;
                    cur_bank_reg  <= use_bank;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> design/trle_back.sv
// back of the encoder: literal store, byte sequencer and word packer
// depends on trle_pkg; takes commands from trle_cmd_fifo
`default_nettype none

module trle_back #(
    parameter int MAX_RUN        = trle_pkg::MAX_RUN_DEF,
    parameter int BYTES_PER_WORD = trle_pkg::BYTES_PER_WORD_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         q_empty,
    input  trle_pkg::cmd_t                    q_head,
    output logic                              q_pop,
    input  trle_pkg::lit_wr_t                 lit_wr,
    output logic [1:0]                        bank_release,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [trle_pkg::WORD_W-1:0]       m_packed_bytes,
    output logic [trle_pkg::COUNT_W-1:0]      m_byte_count,
    output logic                              m_ends_row,
    output logic                              m_last_of_burst
);

    localparam int IDX_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam int RL    = trle_pkg::RUN_LEN_W;
    localparam int PXW   = trle_pkg::PIXEL_W;
    localparam int LW    = trle_pkg::LANE_W;
    localparam int NW    = trle_pkg::COUNT_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_HDR1 = 3'd1;
    localparam logic [2:0] ST_LIT1 = 3'd2;
    localparam logic [2:0] ST_HDR2 = 3'd3;
    localparam logic [2:0] ST_LIT2 = 3'd4;
    localparam logic [2:0] ST_MARK = 3'd5;

    logic [PXW-1:0] lit_mem [2][MAX_RUN];

    logic [2:0]           state_reg, state_next;
    trle_pkg::cmd_t       cmd_reg, cmd_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;

    logic                 s2_valid_reg, s2_lit_reg, s2_last_reg, s2_mark_reg;
    logic [PXW-1:0]       s2_byte_reg, rd_reg;
    logic                 req_valid, req_lit, req_last, req_mark;
    logic [PXW-1:0]       req_byte;
    logic                 rd_bank;
    logic [IDX_W-1:0]     rd_idx;
    logic [2:0]           after1, after2;
    logic [RL-1:0]        idx_inc;
    logic                 lit_end;

    logic [trle_pkg::WORD_W-1:0] acc_reg, acc_next;
    logic [LW-1:0]        acc_cnt_reg;
    logic                 s2_done, advance;
    logic [PXW-1:0]       cur_byte;

    logic                 out_valid_reg, out_ends_reg, out_last_reg;
    logic [trle_pkg::WORD_W-1:0] out_data_reg;
    logic [NW-1:0]        out_cnt_reg;

    // stall when a word completes and the output register cannot take it
    assign s2_done = s2_last_reg || (acc_cnt_reg == LW'(BYTES_PER_WORD - 1));
    assign advance = !(s2_valid_reg && s2_done && out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (lit_wr.en) begin
            lit_mem[lit_wr.bank][lit_wr.addr[IDX_W-1:0]] <= lit_wr.data;
        end
        if (advance) begin
            rd_reg <= lit_mem[rd_bank][rd_idx];
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        idx_next     = idx_reg;
        q_pop        = 1'b0;
        req_valid    = 1'b0;
        req_lit      = 1'b0;
        req_last     = 1'b0;
        req_mark     = 1'b0;
        req_byte     = '0;
        rd_bank      = cmd_reg.c1_bank;
        rd_idx       = idx_reg;
        bank_release = '0;
        lit_end      = 1'b0;
        idx_inc      = RL'(idx_reg) + RL'(1);
        after1       = cmd_reg.c2_opaque ? ST_HDR2 : (cmd_reg.marker ? ST_MARK : ST_IDLE);
        after2       = cmd_reg.marker ? ST_MARK : ST_IDLE;

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop    = advance;
                    cmd_next = q_head;
                    idx_next = '0;
                    if (q_head.c1_kind != trle_pkg::KIND_NONE) begin
                        state_next = ST_HDR1;
                    end else if (q_head.c2_opaque) begin
                        state_next = ST_HDR2;
                    end else begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_HDR1: begin
                req_valid = 1'b1;
                idx_next  = '0;
                if (cmd_reg.c1_kind == trle_pkg::KIND_TRANS) begin
                    req_byte   = trle_pkg::RUN_MARK | PXW'(cmd_reg.c1_len);
                    state_next = after1;
                    req_last   = (after1 == ST_IDLE);
                end else begin
                    req_byte   = PXW'(cmd_reg.c1_len);
                    state_next = ST_LIT1;
                end
            end
            ST_LIT1: begin
                req_valid = 1'b1;
                req_lit   = 1'b1;
                rd_bank   = cmd_reg.c1_bank;
                lit_end   = (idx_inc == cmd_reg.c1_len);
                if (lit_end) begin
                    state_next = after1;
                    req_last   = (after1 == ST_IDLE);
                    bank_release[cmd_reg.c1_bank] = advance;
                end else begin
                    idx_next = IDX_W'(idx_inc);
                end
            end
            ST_HDR2: begin
                req_valid  = 1'b1;
                req_byte   = PXW'(cmd_reg.c2_len);
                idx_next   = '0;
                state_next = ST_LIT2;
            end
            ST_LIT2: begin
                req_valid = 1'b1;
                req_lit   = 1'b1;
                rd_bank   = cmd_reg.c2_bank;
                lit_end   = (idx_inc == cmd_reg.c2_len);
                if (lit_end) begin
                    state_next = after2;
                    req_last   = (after2 == ST_IDLE);
                    bank_release[cmd_reg.c2_bank] = advance;
                end else begin
                    idx_next = IDX_W'(idx_inc);
                end
            end
            ST_MARK: begin
                req_valid  = 1'b1;
                req_mark   = 1'b1;
                req_last   = 1'b1;
                req_byte   = trle_pkg::RUN_MARK;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // drop the current byte into its lane
    always_comb begin
        cur_byte = s2_lit_reg ? rd_reg : s2_byte_reg;
        acc_next = acc_reg;
        for (int j = 0; j < 8; j++) begin
            if (acc_cnt_reg == LW'(j)) begin
                acc_next[j*PXW +: PXW] = cur_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            cmd_reg     <= cmd_next;
            idx_reg     <= idx_next;
            s2_lit_reg  <= req_lit;
            s2_last_reg <= req_last;
            s2_mark_reg <= req_mark;
            s2_byte_reg <= req_byte;
        end
        if (advance && s2_valid_reg && s2_done) begin
            out_data_reg <= acc_next;
            out_cnt_reg  <= NW'(acc_cnt_reg) + NW'(1);
            out_ends_reg <= s2_mark_reg;
            out_last_reg <= s2_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            s2_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            acc_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance && s2_valid_reg && s2_done) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance) begin
                state_reg    <= state_next;
                s2_valid_reg <= req_valid;
                if (s2_valid_reg) begin
                    if (s2_done) begin
                        acc_reg     <= '0;
                        acc_cnt_reg <= '0;
                    end else begin
                        acc_reg     <= acc_next;
                        acc_cnt_reg <= acc_cnt_reg + LW'(1);
                    end
                end
            end
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_packed_bytes  = out_data_reg;
    assign m_byte_count    = out_cnt_reg;
    assign m_ends_row      = out_ends_reg;
    assign m_last_of_burst = out_last_reg;

endmodule

`default_nettype wire

>>> design/transparent_run_length_encoder_core.sv
// transparent run-length encoder top: front, command queue, back; uses trle_pkg
// path: a command passes from the queue into the back's command register, its bytes
// through the byte stage registers into the word lanes, and each word into the output register
// throughput: front takes one pixel per cycle while the queue has room and the next
// literal bank is drained; back, unless the output stalls, sends one encoded byte per cycle and idles between bursts
// reset: synchronous active low, row width 1, no open run; literal store not cleared
`default_nettype none
`include "assert_macros.svh"

module transparent_run_length_encoder_core #(
    parameter int MAX_RUN        = trle_pkg::MAX_RUN_DEF,
    parameter int MAX_WIDTH      = trle_pkg::MAX_WIDTH_DEF,
    parameter int BYTES_PER_WORD = trle_pkg::BYTES_PER_WORD_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [trle_pkg::CFG_W-1:0]    cfg_row_width,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [trle_pkg::PIXEL_W-1:0]  s_pixel,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [trle_pkg::WORD_W-1:0]        m_packed_bytes,
    output logic [trle_pkg::COUNT_W-1:0]       m_byte_count,
    output logic                               m_ends_row,
    output logic                               m_last_of_burst
);

    localparam int NW = trle_pkg::COUNT_W;

    logic              q_push, q_full, q_pop, q_empty;
    trle_pkg::cmd_t    q_cmd, q_head;
    trle_pkg::lit_wr_t lit_wr;
    logic [1:0]        bank_release;

    trle_front #(
        .MAX_RUN   (MAX_RUN),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_row_width (cfg_row_width),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel       (s_pixel),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_cmd),
        .lit_wr        (lit_wr),
        .bank_release  (bank_release)
    );

    trle_cmd_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_head),
        .empty   (q_empty)
    );

    trle_back #(
        .MAX_RUN        (MAX_RUN),
        .BYTES_PER_WORD (BYTES_PER_WORD)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .lit_wr          (lit_wr),
        .bank_release    (bank_release),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_packed_bytes  (m_packed_bytes),
        .m_byte_count    (m_byte_count),
        .m_ends_row      (m_ends_row),
        .m_last_of_burst (m_last_of_burst)
    );

    // only the final word of a burst may be short
    `ASSERT_IMPLIES(a_full_mid_word, aclk, aresetn, m_valid && !m_last_of_burst, m_byte_count == NW'(BYTES_PER_WORD))
    // the row marker is always the final byte of its burst
    `ASSERT_IMPLIES(a_mark_last, aclk, aresetn, m_valid && m_ends_row, m_last_of_burst)
    `ASSERT_IMPLIES(a_count_range, aclk, aresetn, m_valid, m_byte_count != '0 && m_byte_count <= NW'(BYTES_PER_WORD))
    // a full queue that is not drained takes no command in the next cycle
    `ASSERT_NEXT(a_push_space, aclk, aresetn, q_full && !q_pop, !q_push)

endmodule

`default_nettype wire
